/* rtl/spsc_ring_queue_with_drop_count_core_defines.svh */
// ----------------------------------------------------------------------------
// Ring queue assertion macros
// Shared assertion wrappers for the ring queue checkers.
// ----------------------------------------------------------------------------
`ifndef SPSC_RING_QUEUE_WITH_DROP_COUNT_CORE_DEFINES_SVH
`define SPSC_RING_QUEUE_WITH_DROP_COUNT_CORE_DEFINES_SVH

// checked only outside reset
`define SRQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ring queue assertion failed");

// checked during reset as well
`define SRQ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("ring queue reset assertion failed");

`endif

/* rtl/srq_pkg.sv */
// ----------------------------------------------------------------------------
// Ring queue package
// Types, codes and defaults shared by the ring queue modules.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int unsigned SlotsDefault      = 16;
  localparam int unsigned EntryWidthDefault = 32;
  localparam int unsigned MaxEntryWidth     = 64;
  localparam int unsigned WordW             = 32;
  localparam int unsigned CountW            = 4;

  typedef enum logic [1:0] {
    CMD_TRY   = 2'd0,
    CMD_OVR   = 2'd1,
    CMD_DRAIN = 2'd2
  } srq_cmd_e;

  typedef enum logic [1:0] {
    KIND_ENQ   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } srq_kind_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } srq_state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [WordW-1:0] entry_in;
  } srq_in_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              accepted;
    logic [WordW-1:0]  entry_out;
    logic [WordW-1:0]  dropped_count;
    logic [CountW-1:0] processed_count;
    logic [WordW-1:0]  write_count;
    logic              last;
  } srq_out_req_t;

  typedef struct packed {
    srq_cmd_e         op;
    logic [WordW-1:0] entry;
  } srq_op_req_t;

endpackage

/* rtl/srq_ram.sv */
// ----------------------------------------------------------------------------
// Ring queue RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/srq_front.sv */
// ----------------------------------------------------------------------------
// Ring queue front end
// Accepts requests, drops unused commands, buffers operations in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module srq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srq_pkg::srq_in_req_t in_req_i,
  output logic                op_valid_o,
  input  logic                op_ready_i,
  output srq_pkg::srq_op_req_t op_req_o
);

  localparam logic [1:0] QueueFull = 2'd2;

  srq_pkg::srq_op_req_t slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       keep, push, pop;

  always_comb begin
    unique case (in_req_i.cmd) inside
      srq_pkg::CMD_TRY, srq_pkg::CMD_OVR, srq_pkg::CMD_DRAIN: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = (cnt_q != QueueFull);
  assign push       = in_valid_i && in_ready_o && keep;
  assign op_valid_o = (cnt_q != 2'd0);
  assign pop        = op_valid_o && op_ready_i;
  assign op_req_o   = slot_q[rd_q];
  assign cnt_d      = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q].op    <= srq_pkg::srq_cmd_e'(in_req_i.cmd);
      slot_q[wr_q].entry <= in_req_i.entry_in;
    end
  end

endmodule

/* rtl/srq_back.sv */
// ----------------------------------------------------------------------------
// Ring queue back end
// Executes enqueues and drains against the entry RAM, keeps head, read
// index and drop counter, and holds the result register.
// ----------------------------------------------------------------------------
module srq_back #(
  parameter int unsigned Slots      = srq_pkg::SlotsDefault,
  parameter int unsigned EntryWidth = srq_pkg::EntryWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  output logic                 op_ready_o,
  input  srq_pkg::srq_op_req_t op_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srq_pkg::srq_out_req_t out_req_o
);

  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned WordW = srq_pkg::WordW;
  localparam int unsigned ExtW  = srq_pkg::MaxEntryWidth;

  srq_pkg::srq_state_e   state_q, state_d;
  srq_pkg::srq_out_req_t out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [WordW-1:0]      head_q, head_d;
  logic [WordW-1:0]      drop_q, drop_d;
  logic [WordW-1:0]      snap_q, snap_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic [srq_pkg::CountW-1:0] cnt_q, cnt_d;

  logic                  out_adv, pop, ram_we;
  logic [IdxW-1:0]       h, nxt, nt;
  logic [EntryWidth-1:0] ram_wdata, ram_rdata;
  logic [ExtW-1:0]       wide_in, wide_rd;

  assign h          = head_q[IdxW-1:0];
  assign nxt        = h + IdxW'(1);
  assign nt         = rd_idx_q + IdxW'(1);
  assign out_adv    = !out_valid_q || out_ready_i;
  assign op_ready_o = (state_q == srq_pkg::ST_IDLE) && out_adv;
  assign pop        = op_valid_i && op_ready_o;
  assign wide_in    = ExtW'(op_req_i.entry);
  assign ram_wdata  = wide_in[EntryWidth-1:0];
  assign wide_rd    = ExtW'(ram_rdata);

  srq_ram #(
    .Width(EntryWidth),
    .Depth(Slots)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(h),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_d),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srq_pkg::ST_IDLE: begin
        if (pop && op_req_i.op == srq_pkg::CMD_DRAIN && rd_idx_q != h) begin
          state_d = srq_pkg::ST_DRAIN;
        end
      end
      srq_pkg::ST_DRAIN: begin
        if (out_adv && nt == h) begin
          state_d = srq_pkg::ST_IDLE;
        end
      end
      default: state_d = srq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    drop_d      = drop_q;
    snap_d      = snap_q;
    rd_idx_d    = rd_idx_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      srq_pkg::ST_IDLE: begin
        if (pop) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.last  = 1'b1;
          case (op_req_i.op)
            srq_pkg::CMD_TRY: begin
              out_d.kind = srq_pkg::KIND_ENQ;
              if (nxt == rd_idx_q) begin
                drop_d            = drop_q + WordW'(1);
                out_d.write_count = head_q;
              end else begin
                ram_we            = 1'b1;
                head_d            = WordW'(nxt);
                out_d.accepted    = 1'b1;
                out_d.write_count = WordW'(nxt);
              end
            end
            srq_pkg::CMD_OVR: begin
              ram_we            = 1'b1;
              head_d            = head_q + WordW'(1);
              out_d.kind        = srq_pkg::KIND_ENQ;
              out_d.accepted    = 1'b1;
              out_d.write_count = head_q + WordW'(1);
            end
            srq_pkg::CMD_DRAIN: begin
              snap_d = drop_q;
              drop_d = '0;
              cnt_d  = '0;
              if (rd_idx_q == h) begin
                out_d.kind          = srq_pkg::KIND_EMPTY;
                out_d.dropped_count = drop_q;
              end else begin
                out_valid_d = 1'b0;
              end
            end
            default: out_valid_d = 1'b0;
          endcase
        end
      end
      srq_pkg::ST_DRAIN: begin
        if (out_adv) begin
          out_valid_d           = 1'b1;
          out_d                 = '0;
          out_d.kind            = srq_pkg::KIND_ENTRY;
          out_d.entry_out       = wide_rd[WordW-1:0];
          out_d.dropped_count   = snap_q;
          out_d.processed_count = cnt_q + srq_pkg::CountW'(1);
          out_d.last            = (nt == h);
          cnt_d                 = cnt_q + srq_pkg::CountW'(1);
          rd_idx_d              = nt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      drop_q      <= '0;
      rd_idx_q    <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      drop_q      <= drop_d;
      rd_idx_q    <= rd_idx_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    snap_q <= snap_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* rtl/spsc_ring_queue_with_drop_count_core.sv */
// ----------------------------------------------------------------------------
// Ring queue with drop count
// Top level: front end with request queue, back end with entry RAM.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are executed in order by the back end.
// Enqueues (try or overwrite) stream at one per cycle while the output is
// not stalled. A drain of a non-empty ring first fetches the oldest entry
// through the registered read port of the entry RAM, then returns one entry
// per cycle while the output is not stalled; a drain of an empty ring
// returns a single empty reply. Command code 3 is accepted and discarded.
module spsc_ring_queue_with_drop_count_core #(
  parameter int unsigned SLOTS       = srq_pkg::SlotsDefault,
  parameter int unsigned ENTRY_WIDTH = srq_pkg::EntryWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  srq_pkg::srq_in_req_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output srq_pkg::srq_out_req_t out_req_o
);

  logic                 op_valid, op_ready;
  srq_pkg::srq_op_req_t op_req;

  srq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_req_i  (in_req_i),
    .op_valid_o(op_valid),
    .op_ready_i(op_ready),
    .op_req_o  (op_req)
  );

  srq_back #(
    .Slots     (SLOTS),
    .EntryWidth(ENTRY_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .op_req_i   (op_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

endmodule

/* rtl/srq_checker.sv */
// ----------------------------------------------------------------------------
// Ring queue checker
// Port-level assertions for the ring queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "spsc_ring_queue_with_drop_count_core_defines.svh"

module srq_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input srq_pkg::srq_out_req_t out_req_o
);

  logic                       out_fire;
  logic                       mid_drain;
  logic [srq_pkg::CountW-1:0] proc_next;

  assign out_fire  = out_valid_o && out_ready_i;
  assign mid_drain = out_fire && out_req_o.kind == srq_pkg::KIND_ENTRY && !out_req_o.last;
  assign proc_next = out_req_o.processed_count + srq_pkg::CountW'(1);

  `SRQ_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
  `SRQ_ASSERT(a_drain_next, mid_drain |=> out_valid_o && out_req_o.kind == srq_pkg::KIND_ENTRY)
  `SRQ_ASSERT(a_drain_count, mid_drain |=> out_req_o.processed_count == $past(proc_next))
  `SRQ_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_valid_o)

endmodule

bind spsc_ring_queue_with_drop_count_core srq_checker u_srq_checker (.*);
